// ===== hw/rtl/smvs_pkg.sv =====
// ----------------------------------------------------------------------------
// smvs_pkg: shared types and codes of the stepper move verify sequencer
// Sequence phases, request codes, register selectors, outcomes and the
// structs that pass state, settings and results between modules.
// ----------------------------------------------------------------------------
package smvs_pkg;

  // sequence phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_READ_POS  = 4'd1;
  localparam logic [3:0] PH_CLEAR     = 4'd2;
  localparam logic [3:0] PH_ENC_START = 4'd3;
  localparam logic [3:0] PH_RAMPMODE  = 4'd4;
  localparam logic [3:0] PH_TARGET    = 4'd5;
  localparam logic [3:0] PH_POLL      = 4'd6;
  localparam logic [3:0] PH_POLL_WAIT = 4'd7;
  localparam logic [3:0] PH_SETTLE    = 4'd8;
  localparam logic [3:0] PH_ENC_END   = 4'd9;
  localparam logic [3:0] PH_RETARGET  = 4'd10;
  localparam logic [3:0] PH_BACKOFF   = 4'd11;

  // request codes
  localparam logic [1:0] RQ_WRITE  = 2'd0;
  localparam logic [1:0] RQ_READ   = 2'd1;
  localparam logic [1:0] RQ_DELAY  = 2'd2;
  localparam logic [1:0] RQ_FINISH = 2'd3;

  // register selectors
  localparam logic [2:0] SEL_GSTAT    = 3'd0;
  localparam logic [2:0] SEL_RAMPMODE = 3'd1;
  localparam logic [2:0] SEL_TARGET   = 3'd2;
  localparam logic [2:0] SEL_ACTUAL   = 3'd3;
  localparam logic [2:0] SEL_ENCODER  = 3'd4;
  localparam logic [2:0] SEL_RAMPSTAT = 3'd5;

  // outcomes
  localparam logic [1:0] OUT_OK        = 2'd0;
  localparam logic [1:0] OUT_BUS       = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT   = 2'd2;
  localparam logic [1:0] OUT_DEVIATION = 2'd3;

  // operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WAIT_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

  // configuration reset values
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
  localparam logic [23:0] WAIT_LIMIT_RST  = 24'd5000;
  localparam logic [30:0] TOLERANCE_RST   = 31'd256;

  // fixed values of the sequence
  localparam logic [31:0] BUS_FAIL_WORD   = 32'hFFFF_FFFF;
  localparam int unsigned REACHED_BIT     = 9;
  localparam logic [31:0] GSTAT_CLEAR     = 32'h0000_0007;
  localparam logic [5:0]  DELAY_POLL_MS   = 6'd5;
  localparam logic [5:0]  DELAY_SETTLE_MS = 6'd10;
  localparam logic [5:0]  DELAY_BACKOFF_MS = 6'd50;
  localparam logic [24:0] POLL_STEP_MS    = 25'd5;

  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] goal;
    logic [31:0] distance;
    logic [31:0] enc_start;
    logic [24:0] elapsed;
    logic [7:0]  attempt;
  } smvs_state_t;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [23:0] wait_limit_ms;
    logic [30:0] tolerance;
  } smvs_cfg_t;

  typedef struct packed {
    logic [1:0]  request;
    logic [2:0]  register_select;
    logic [31:0] write_value;
    logic [5:0]  delay_ms;
    logic [1:0]  outcome;
  } smvs_result_t;

endpackage

// ===== hw/rtl/smvs_step.sv =====
// ----------------------------------------------------------------------------
// smvs_step: one step of the move sequence
// Works out the next sequence state and the request for one input word.
// ----------------------------------------------------------------------------
module smvs_step
  import smvs_pkg::*;
(
  input  smvs_state_t  state,
  input  smvs_cfg_t    cfg,
  input  logic         operation,
  input  logic [31:0]  goal_position,
  input  logic [31:0]  reply_data,
  output smvs_state_t  state_nxt,
  output logic         res_vld,
  output smvs_result_t res
);

  logic [31:0] dev_raw;
  logic [31:0] dev_abs;
  logic        dev_ok;
  logic [24:0] elapsed_inc;
  logic [7:0]  attempt_inc;
  logic        wait_left;
  logic        wait_left_inc;

  // deviation of the measured move from the planned distance
  assign dev_raw = (reply_data - state.enc_start) - state.distance;
  assign dev_abs = dev_raw[31] ? (32'd0 - dev_raw) : dev_raw;
  assign dev_ok  = (dev_abs <= {1'b0, cfg.tolerance});

  // poll timer and attempt counter
  assign elapsed_inc   = state.elapsed + POLL_STEP_MS;
  assign attempt_inc   = state.attempt + 8'd1;
  assign wait_left     = (state.elapsed < {1'b0, cfg.wait_limit_ms});
  assign wait_left_inc = (elapsed_inc < {1'b0, cfg.wait_limit_ms});

  // sequence decode
  always_comb begin
    state_nxt = state;
    res_vld   = 1'b1;
    res       = '0;
    if (operation == OP_START) begin
      state_nxt.goal      = goal_position;
      state_nxt.phase     = PH_READ_POS;
      res.request         = RQ_READ;
      res.register_select = SEL_ACTUAL;
    end else begin
      case (state.phase)
        PH_READ_POS: begin
          state_nxt.distance = state.goal - reply_data;
          state_nxt.attempt  = 8'd0;
          if (cfg.retry_limit == 8'd0) begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_DEVIATION;
          end else begin
            state_nxt.phase     = PH_CLEAR;
            res.request         = RQ_WRITE;
            res.register_select = SEL_GSTAT;
            res.write_value     = GSTAT_CLEAR;
          end
        end
        PH_CLEAR: begin
          state_nxt.phase     = PH_ENC_START;
          res.request         = RQ_READ;
          res.register_select = SEL_ENCODER;
        end
        PH_ENC_START: begin
          state_nxt.enc_start = reply_data;
          state_nxt.phase     = PH_RAMPMODE;
          res.request         = RQ_WRITE;
          res.register_select = SEL_RAMPMODE;
        end
        PH_RAMPMODE: begin
          state_nxt.elapsed   = 25'd0;
          state_nxt.phase     = PH_TARGET;
          res.request         = RQ_WRITE;
          res.register_select = SEL_TARGET;
          res.write_value     = state.goal;
        end
        PH_TARGET: begin
          if (wait_left) begin
            state_nxt.phase     = PH_POLL;
            res.request         = RQ_READ;
            res.register_select = SEL_RAMPSTAT;
          end else begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_TIMEOUT;
          end
        end
        PH_POLL: begin
          if (reply_data == BUS_FAIL_WORD || reply_data == 32'd0) begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_BUS;
          end else if (reply_data[REACHED_BIT]) begin
            state_nxt.phase = PH_SETTLE;
            res.request     = RQ_DELAY;
            res.delay_ms    = DELAY_SETTLE_MS;
          end else begin
            state_nxt.phase = PH_POLL_WAIT;
            res.request     = RQ_DELAY;
            res.delay_ms    = DELAY_POLL_MS;
          end
        end
        PH_POLL_WAIT: begin
          state_nxt.elapsed = elapsed_inc;
          if (wait_left_inc) begin
            state_nxt.phase     = PH_POLL;
            res.request         = RQ_READ;
            res.register_select = SEL_RAMPSTAT;
          end else begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_TIMEOUT;
          end
        end
        PH_SETTLE: begin
          state_nxt.phase     = PH_ENC_END;
          res.request         = RQ_READ;
          res.register_select = SEL_ENCODER;
        end
        PH_ENC_END: begin
          if (dev_ok) begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_OK;
          end else begin
            state_nxt.phase     = PH_RETARGET;
            res.request         = RQ_READ;
            res.register_select = SEL_ENCODER;
          end
        end
        PH_RETARGET: begin
          state_nxt.goal  = reply_data + state.distance;
          state_nxt.phase = PH_BACKOFF;
          res.request     = RQ_DELAY;
          res.delay_ms    = DELAY_BACKOFF_MS;
        end
        PH_BACKOFF: begin
          state_nxt.attempt = attempt_inc;
          if (attempt_inc >= cfg.retry_limit) begin
            state_nxt.phase = PH_IDLE;
            res.request     = RQ_FINISH;
            res.outcome     = OUT_DEVIATION;
          end else begin
            state_nxt.phase     = PH_CLEAR;
            res.request         = RQ_WRITE;
            res.register_select = SEL_GSTAT;
            res.write_value     = GSTAT_CLEAR;
          end
        end
        default: begin
          // reply with no move running
          state_nxt.phase = PH_IDLE;
          res_vld         = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/stepper_move_verify_sequencer.sv =====
// Path: a word taken into the input register passes through the step logic
//   into the result register, which then shows its request.
// Throughput: one word per cycle; the input register and the result register
//   each take a new word in any cycle in which the result register is free
//   or being taken.
// Reset (rst_n low, synchronous): sequence idle, both registers empty,
//   settings back to retry 3, wait 5000 ms, tolerance 256.
// ----------------------------------------------------------------------------
// stepper_move_verify_sequencer: supervises one encoder-verified move
// Input register, sequence state and settings, step logic and result
// register.
// ----------------------------------------------------------------------------
module stepper_move_verify_sequencer
  import smvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_goal_position,
  input  logic [31:0]        in_reply_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_request,
  output logic [2:0]         out_register_select,
  output logic [31:0]        out_write_value,
  output logic [5:0]         out_delay_ms,
  output logic [1:0]         out_outcome
);

  logic         in_vld_r;
  logic         in_vld_nxt;
  logic         op_r;
  logic [31:0]  goal_r;
  logic [31:0]  data_r;
  smvs_state_t  state_r;
  smvs_state_t  state_nxt;
  smvs_cfg_t    cfg_r;
  smvs_cfg_t    cfg_nxt;
  logic         out_vld_r;
  logic         out_vld_nxt;
  smvs_result_t out_r;
  smvs_result_t res;
  logic         res_vld;
  logic         advance;
  logic         in_take;

  // handshake
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_operation;
      goal_r <= $unsigned(in_goal_position);
      data_r <= in_reply_data;
    end
  end

  // settings
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit   = cfg_wdata[7:0];
        CFG_WAIT_LIMIT:  cfg_nxt.wait_limit_ms = cfg_wdata[23:0];
        CFG_TOLERANCE:   cfg_nxt.tolerance     = cfg_wdata;
        default:         cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit   <= RETRY_LIMIT_RST;
      cfg_r.wait_limit_ms <= WAIT_LIMIT_RST;
      cfg_r.tolerance     <= TOLERANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // step logic
  smvs_step u_step (
    .state         (state_r),
    .cfg           (cfg_r),
    .operation     (op_r),
    .goal_position (goal_r),
    .reply_data    (data_r),
    .state_nxt     (state_nxt),
    .res_vld       (res_vld),
    .res           (res)
  );

  // sequence state, idle phase is code zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = res_vld;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_request         = out_r.request;
  assign out_register_select = out_r.register_select;
  assign out_write_value     = out_r.write_value;
  assign out_delay_ms        = out_r.delay_ms;
  assign out_outcome         = out_r.outcome;

`ifndef SYNTHESIS
  // stall only while a word waits in the input register
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  // a finished request leaves the sequence idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_vld && res.request == RQ_FINISH) |=> (state_r.phase == PH_IDLE))
    else $error("sequence not idle after finish");

  // delay requests carry one of the three lengths
  a_delay_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.request == RQ_DELAY) |->
      (out_r.delay_ms == DELAY_POLL_MS || out_r.delay_ms == DELAY_SETTLE_MS ||
       out_r.delay_ms == DELAY_BACKOFF_MS))
    else $error("bad delay length");

  // a reply with no move running gives no result
  a_idle_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && op_r == OP_REPLY && state_r.phase == PH_IDLE) |-> !res_vld)
    else $error("result for reply while idle");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stepper move verify sequencer
// Replies are chosen from a local copy of the sequence state, so most traffic
// is well-formed moves with random data. Every accepted word is run through
// the same sequence locally and the request it should cause is queued. The
// queued requests are then compared field by field with what comes out.
// ----------------------------------------------------------------------------
module tb;
  import smvs_pkg::*;

  localparam int LATENCY     = 2;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_LIMIT = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_START;
  logic [31:0] in_goal_position = '0;
  logic [31:0] in_reply_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_request;
  logic [2:0]  out_register_select;
  logic [31:0] out_write_value;
  logic [5:0]  out_delay_ms;
  logic [1:0]  out_outcome;

  // local copy of the move sequence and its settings
  logic [3:0]  ph = PH_IDLE;
  logic [31:0] tgt_goal = '0;
  logic [31:0] plan_dist = '0;
  logic [31:0] enc_origin = '0;
  logic [24:0] poll_ms = '0;
  logic [7:0]  tries = '0;
  logic [7:0]  lim_retry = RETRY_LIMIT_RST;
  logic [23:0] lim_wait_ms = WAIT_LIMIT_RST;
  logic [30:0] lim_tol = TOLERANCE_RST;

  smvs_result_t expected_requests[$];
  int mismatches = 0;

  // random idling on both sides, long hold-off on the result side
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  stepper_move_verify_sequencer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_goal_position    (in_goal_position),
    .in_reply_data       (in_reply_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_request         (out_request),
    .out_register_select (out_register_select),
    .out_write_value     (out_write_value),
    .out_delay_ms        (out_delay_ms),
    .out_outcome         (out_outcome)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // sequence prediction
  // ---------------------------------------------------------------------------

  function automatic smvs_result_t finish_move(input logic [1:0] oc);
    smvs_result_t r;
    r = '0;
    r.request = RQ_FINISH;
    r.outcome = oc;
    ph = PH_IDLE;
    return r;
  endfunction

  function automatic smvs_result_t poll_or_give_up();
    smvs_result_t r;
    r = '0;
    if (poll_ms < {1'b0, lim_wait_ms}) begin
      ph = PH_POLL;
      r.request = RQ_READ;
      r.register_select = SEL_RAMPSTAT;
    end else begin
      r = finish_move(OUT_TIMEOUT);
    end
    return r;
  endfunction

  task automatic advance_sequence(input logic op, input logic [31:0] goal,
                                  input logic [31:0] data);
    smvs_result_t r;
    logic [31:0] dev;
    bit produced;
    r = '0;
    produced = 1'b1;
    if (op == OP_START) begin
      tgt_goal = goal;
      ph = PH_READ_POS;
      r.request = RQ_READ;
      r.register_select = SEL_ACTUAL;
    end else begin
      case (ph)
        PH_READ_POS: begin
          plan_dist = tgt_goal - data;
          tries = '0;
          if (tries >= lim_retry) begin
            r = finish_move(OUT_DEVIATION);
          end else begin
            ph = PH_CLEAR;
            r.request = RQ_WRITE;
            r.register_select = SEL_GSTAT;
            r.write_value = GSTAT_CLEAR;
          end
        end
        PH_CLEAR: begin
          ph = PH_ENC_START;
          r.request = RQ_READ;
          r.register_select = SEL_ENCODER;
        end
        PH_ENC_START: begin
          enc_origin = data;
          ph = PH_RAMPMODE;
          r.request = RQ_WRITE;
          r.register_select = SEL_RAMPMODE;
        end
        PH_RAMPMODE: begin
          poll_ms = '0;
          ph = PH_TARGET;
          r.request = RQ_WRITE;
          r.register_select = SEL_TARGET;
          r.write_value = tgt_goal;
        end
        PH_TARGET: r = poll_or_give_up();
        PH_POLL: begin
          if (data == BUS_FAIL_WORD || data == '0) begin
            r = finish_move(OUT_BUS);
          end else if (data[REACHED_BIT]) begin
            ph = PH_SETTLE;
            r.request = RQ_DELAY;
            r.delay_ms = DELAY_SETTLE_MS;
          end else begin
            ph = PH_POLL_WAIT;
            r.request = RQ_DELAY;
            r.delay_ms = DELAY_POLL_MS;
          end
        end
        PH_POLL_WAIT: begin
          poll_ms = poll_ms + POLL_STEP_MS;
          r = poll_or_give_up();
        end
        PH_SETTLE: begin
          ph = PH_ENC_END;
          r.request = RQ_READ;
          r.register_select = SEL_ENCODER;
        end
        PH_ENC_END: begin
          // deviation magnitude is taken unsigned, so 2^31 never passes
          dev = (data - enc_origin) - plan_dist;
          if (dev[31]) dev = -dev;
          if (dev <= {1'b0, lim_tol}) begin
            r = finish_move(OUT_OK);
          end else begin
            ph = PH_RETARGET;
            r.request = RQ_READ;
            r.register_select = SEL_ENCODER;
          end
        end
        PH_RETARGET: begin
          tgt_goal = data + plan_dist;
          ph = PH_BACKOFF;
          r.request = RQ_DELAY;
          r.delay_ms = DELAY_BACKOFF_MS;
        end
        PH_BACKOFF: begin
          tries = tries + 8'd1;
          if (tries >= lim_retry) begin
            r = finish_move(OUT_DEVIATION);
          end else begin
            ph = PH_CLEAR;
            r.request = RQ_WRITE;
            r.register_select = SEL_GSTAT;
            r.write_value = GSTAT_CLEAR;
          end
        end
        default: begin
          // a reply with no move running is dropped
          ph = PH_IDLE;
          produced = 1'b0;
        end
      endcase
    end
    if (produced) expected_requests.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_requests
    smvs_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_requests.size() == 0) begin
        report_mismatch($sformatf("unexpected word: request %0d sel %0d outcome %0d",
                                  out_request, out_register_select, out_outcome));
      end else begin
        want = expected_requests.pop_front();
        if (out_request !== want.request)
          report_mismatch($sformatf("request %0d, wanted %0d", out_request, want.request));
        if (out_register_select !== want.register_select)
          report_mismatch($sformatf("register_select %0d, wanted %0d",
                                    out_register_select, want.register_select));
        if (out_write_value !== want.write_value)
          report_mismatch($sformatf("write_value %h, wanted %h",
                                    out_write_value, want.write_value));
        if (out_delay_ms !== want.delay_ms)
          report_mismatch($sformatf("delay_ms %0d, wanted %0d", out_delay_ms, want.delay_ms));
        if (out_outcome !== want.outcome)
          report_mismatch($sformatf("outcome %0d, wanted %0d", out_outcome, want.outcome));
      end
    end
  end

  // result side stall: random idling or one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 14);
      if (!hold_req) hold_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one word, hold it until taken, then predict its request
  task automatic send_word(input logic op, input logic [31:0] goal,
                           input logic [31:0] data);
    int gap;
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_goal_position <= goal;
    in_reply_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequence(op, goal, data);
  endtask

  task automatic start_move(input logic [31:0] goal);
    send_word(OP_START, goal, $urandom);
  endtask

  task automatic answer(input logic [31:0] data);
    send_word(OP_REPLY, $urandom, data);
  endtask

  task automatic wait_drained();
    while (expected_requests.size() != 0) @(posedge clk);
  endtask

  // block idle: nothing pending and nothing left inside
  task automatic settle_idle();
    in_valid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_setting(input logic [1:0] idx, input logic [30:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RETRY_LIMIT: lim_retry = value[7:0];
      CFG_WAIT_LIMIT:  lim_wait_ms = value[23:0];
      CFG_TOLERANCE:   lim_tol = value[30:0];
      default: ;
    endcase
  endtask

  // write all three settings, with junk above the retry and wait register widths
  task automatic apply_settings(input logic [7:0] retry, input logic [23:0] wait_ms,
                                input logic [30:0] tol);
    logic [31:0] w;
    w = $urandom;
    w[7:0] = retry;
    write_setting(CFG_RETRY_LIMIT, w[30:0]);
    w = $urandom;
    w[23:0] = wait_ms;
    write_setting(CFG_WAIT_LIMIT, w[30:0]);
    write_setting(CFG_TOLERANCE, tol);
  endtask

  // reply data that steers the move according to where it stands
  function automatic logic [31:0] choose_reply();
    logic [31:0] word;
    logic [31:0] span;
    logic [31:0] delta;
    word = $urandom;
    case (ph)
      PH_POLL: begin
        case ($urandom_range(9))
          0: word = BUS_FAIL_WORD;
          1: word = '0;
          2, 3, 4: word[REACHED_BIT] = 1'b1;
          default: begin
            word[REACHED_BIT] = 1'b0;
            if (word == '0) word = 32'd1;
          end
        endcase
      end
      PH_ENC_END: begin
        span = {1'b0, lim_tol};
        case ($urandom_range(7))
          0: delta = '0;
          1: delta = span;
          2: delta = -span;
          3: delta = span + 32'd1;
          4: delta = 32'h8000_0000;
          5: delta = $urandom;
          default: begin
            delta = $urandom % (span + 32'd1);
            if ($urandom_range(1) == 1) delta = -delta;
          end
        endcase
        word = enc_origin + plan_dist + delta;
      end
      default: ;
    endcase
    return word;
  endfunction

  // mostly complete moves, some abandoned by a new start, some stray replies
  task automatic drive_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if (ph == PH_IDLE) begin
        if ($urandom_range(9) == 0) begin
          answer($urandom);
        end else begin
          start_move($urandom);
          sent++;
        end
      end else if ($urandom_range(39) == 0) begin
        start_move($urandom);
        sent++;
      end else begin
        answer(choose_reply());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_moves();
    // stray reply with nothing running
    answer($urandom);
    // extreme goal and position, all-ones encoder read, deviation right at tolerance
    start_move(32'h8000_0000);
    answer(32'h7FFF_FFFF);
    answer($urandom);
    answer(BUS_FAIL_WORD);
    answer($urandom);
    answer($urandom);
    answer(32'd1 << REACHED_BIT);
    answer($urandom);
    answer(enc_origin + plan_dist + {1'b0, lim_tol});
    // a new start abandons the running move; zero ramp status is a bus failure
    start_move(32'h7FFF_FFFF);
    answer('0);
    start_move('0);
    answer(BUS_FAIL_WORD);
    repeat (4) answer($urandom);
    answer('0);
  endtask

  task automatic test_settings_extremes();
    logic [31:0] junk;
    // no attempts allowed: deviation right after the position read
    settle_idle();
    apply_settings(8'd0, WAIT_LIMIT_RST, TOLERANCE_RST);
    start_move($urandom);
    answer($urandom);
    // no polling time: timeout right after the target write
    settle_idle();
    apply_settings(8'd255, 24'd0, 31'd0);
    start_move($urandom);
    repeat (5) answer($urandom);
    // widest tolerance still rejects a 2^31 deviation
    settle_idle();
    apply_settings(8'd1, 24'hFF_FFFF, 31'h7FFF_FFFF);
    junk = $urandom;
    write_setting(CFG_UNUSED, junk[30:0]);
    start_move($urandom);
    repeat (5) answer($urandom);
    answer(32'd1 << REACHED_BIT);
    answer($urandom);
    answer(enc_origin + plan_dist + 32'h8000_0000);
    answer($urandom);
    answer($urandom);
  endtask

  task automatic test_backpressure();
    settle_idle();
    apply_settings(8'd2, 24'd30, 31'd64);
    idle_on <= 1'b0;
    // result side holds off while words keep coming
    hold_req <= 1'b1;
    drive_random(40);
    hold_req <= 1'b0;
    // sender pauses mid-move until everything is out
    drive_random(10);
    in_valid <= 1'b0;
    wait_drained();
    drive_random(30);
    idle_on <= 1'b1;
  endtask

  task automatic test_random_moves();
    logic [31:0] r1, r2, r3;
    for (int k = 0; k < 6; k++) begin
      settle_idle();
      r1 = $urandom;
      r2 = $urandom;
      r3 = $urandom;
      case (k)
        0: begin
          r1 = 32'(RETRY_LIMIT_RST);
          r2 = 32'(WAIT_LIMIT_RST);
          r3 = 32'(TOLERANCE_RST);
        end
        1: begin
          r1 = $urandom_range(0, 4);
          r2 = $urandom_range(0, 40);
          r3 = $urandom_range(0, 1000);
        end
        2: begin
          r1 = 32'd255;
          r3 = '0;
        end
        3: ;
        4: begin
          r1 = 32'd1;
          r2 = $urandom_range(0, 20);
          r3 = 32'h7FFF_FFFF;
        end
        default: begin
          // long stretch with no idling on either side
          r1 = 32'd2;
          r2 = 32'd10;
          r3 = $urandom_range(0, 50);
          idle_on <= 1'b0;
        end
      endcase
      apply_settings(r1[7:0], r2[23:0], r3[30:0]);
      drive_random(80);
    end
    idle_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_moves();
    test_settings_extremes();
    test_backpressure();
    test_random_moves();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_requests.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_requests.size() != 0)
      report_mismatch($sformatf("%0d requests never came out", expected_requests.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
